[hdl/pba_pkg.sv]
// Shared types, codes and helpers of the purgeable block allocator.
`default_nettype none

package pba_pkg;

   // Address and link widths.
   localparam int ADDR_W = 24;
   localparam int LINK_W = 6;
   localparam int OWNER_W = 8;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LINK_W-1:0] link_type;

   // Link value that marks the end of a chain.
   localparam link_type NIL = 6'd63;

   // Commands.
   localparam logic [2:0] CMD_ALLOC   = 3'd0;
   localparam logic [2:0] CMD_FREE    = 3'd1;
   localparam logic [2:0] CMD_PURGE   = 3'd2;
   localparam logic [2:0] CMD_LOCK    = 3'd3;
   localparam logic [2:0] CMD_COMPACT = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_DONE   = 2'd0;
   localparam logic [1:0] KIND_PURGED = 2'd1;
   localparam logic [1:0] KIND_MOVED  = 2'd2;
   localparam logic [1:0] KIND_GRANT  = 2'd3;

   // Status codes.
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_NOMEM    = 3'd1;
   localparam logic [2:0] STAT_NOTFOUND = 3'd2;
   localparam logic [2:0] STAT_NODESC   = 3'd3;
   localparam logic [2:0] STAT_HALTED   = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HEAP_BASE = 2'd0;
   localparam logic [1:0] CSR_HEAP_SIZE = 2'd1;
   localparam logic [1:0] CSR_STOP      = 2'd2;

   // One command item.
   typedef struct packed {
      logic [2:0]         command;
      logic [OWNER_W-1:0] handle;
      addr_type           size;
      logic [1:0]         purge_level;
      logic               lock_flag;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [1:0]         kind;
      logic [OWNER_W-1:0] owner;
      addr_type           address;
      addr_type           source_address;
      addr_type           move_length;
      logic [2:0]         status;
      logic               error_flag;
      logic               last;
   } rsp_type;

   // Block descriptor without its link.
   typedef struct packed {
      addr_type           start;
      addr_type           length;
      logic               locked;
      logic [1:0]         purge;
      logic [OWNER_W-1:0] owner;
   } desc_type;

   // Access to the descriptor and link memories.
   typedef struct packed {
      logic     rd_en;
      link_type rd_addr;
      logic     dwr_en;
      link_type dwr_addr;
      desc_type dwr_data;
      logic     lwr_en;
      link_type lwr_addr;
      link_type lwr_data;
   } mem_req_type;

   // Configuration seen by the sequencer.
   typedef struct packed {
      addr_type base;
      addr_type end_addr;
      logic     stop_on_error;
   } cfg_type;

   // Builds one result item.
   function automatic rsp_type mk_rsp(input logic [1:0] kind,
                                      input logic [OWNER_W-1:0] owner,
                                      input addr_type address,
                                      input addr_type source_address,
                                      input addr_type move_length,
                                      input logic [2:0] status,
                                      input logic error_flag,
                                      input logic last);
      rsp_type r;
      r.kind = kind;
      r.owner = owner;
      r.address = address;
      r.source_address = source_address;
      r.move_length = move_length;
      r.status = status;
      r.error_flag = error_flag;
      r.last = last;
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/pba_desc_mem.sv]
// Descriptor and link memories with registered read.
`default_nettype none

module pba_desc_mem #(
   parameter int MAX_BLOCKS = 32
) (
   input  wire logic                 clock,
   input  wire pba_pkg::mem_req_type mreq,
   output pba_pkg::desc_type         rd_desc,
   output pba_pkg::link_type         rd_link
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   pba_pkg::desc_type desc_mem [MAX_BLOCKS];
   pba_pkg::link_type link_mem [MAX_BLOCKS];
   pba_pkg::desc_type rd_desc_ff;
   pba_pkg::link_type rd_link_ff;

   // Writes.
   always_ff @(posedge clock) begin
      if (mreq.dwr_en) begin
         desc_mem[mreq.dwr_addr[IDX_W-1:0]] <= mreq.dwr_data;
      end
      if (mreq.lwr_en) begin
         link_mem[mreq.lwr_addr[IDX_W-1:0]] <= mreq.lwr_data;
      end
   end

   // Registered read; a write to the same entry in the same cycle is forwarded.
   always_ff @(posedge clock) begin
      if (mreq.rd_en) begin
         if (mreq.dwr_en && mreq.dwr_addr == mreq.rd_addr) begin
            rd_desc_ff <= mreq.dwr_data;
         end else begin
            rd_desc_ff <= desc_mem[mreq.rd_addr[IDX_W-1:0]];
         end
         if (mreq.lwr_en && mreq.lwr_addr == mreq.rd_addr) begin
            rd_link_ff <= mreq.lwr_data;
         end else begin
            rd_link_ff <= link_mem[mreq.rd_addr[IDX_W-1:0]];
         end
      end
   end

   assign rd_desc = rd_desc_ff;
   assign rd_link = rd_link_ff;

endmodule

`default_nettype wire

[hdl/pba_seq.sv]
// Command sequencer that walks the descriptor list in memory.
`default_nettype none

module pba_seq #(
   parameter int MAX_BLOCKS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire pba_pkg::req_type     req,
   output logic                      busy,
   input  wire pba_pkg::cfg_type     cfg,
   input  wire logic                 reinit,
   output pba_pkg::mem_req_type      mreq,
   input  wire pba_pkg::desc_type    rd_desc,
   input  wire pba_pkg::link_type    rd_link,
   output logic                      emit_valid,
   output pba_pkg::rsp_type          emit
);

   localparam pba_pkg::link_type MAXB = pba_pkg::link_type'(MAX_BLOCKS);
   localparam pba_pkg::link_type LAST_IDX = pba_pkg::link_type'(MAX_BLOCKS - 1);
   localparam pba_pkg::link_type HEAD = 6'd0;
   localparam pba_pkg::link_type HIGH = 6'd1;
   localparam pba_pkg::link_type FIRST_FREE = 6'd2;

   localparam logic [1:0] PASS_ROVER   = 2'd0;
   localparam logic [1:0] PASS_HEAD    = 2'd1;
   localparam logic [1:0] PASS_COMPACT = 2'd2;

   localparam logic [5:0] S_IDLE    = 6'd0;
   localparam logic [5:0] S_INIT    = 6'd1;
   localparam logic [5:0] S_HALT    = 6'd2;
   localparam logic [5:0] S_BADH    = 6'd3;
   localparam logic [5:0] S_DONE0   = 6'd4;
   localparam logic [5:0] S_NF      = 6'd5;
   localparam logic [5:0] S_NODESC  = 6'd6;
   localparam logic [5:0] C_RD      = 6'd7;
   localparam logic [5:0] C_PROC    = 6'd8;
   localparam logic [5:0] C_UNLINK  = 6'd9;
   localparam logic [5:0] Q_RD0     = 6'd10;
   localparam logic [5:0] Q_HEAD    = 6'd11;
   localparam logic [5:0] Q_RD      = 6'd12;
   localparam logic [5:0] Q_PROC    = 6'd13;
   localparam logic [5:0] A_TAKE    = 6'd14;
   localparam logic [5:0] A_TAKE2   = 6'd15;
   localparam logic [5:0] A_PASS    = 6'd16;
   localparam logic [5:0] A_LS      = 6'd17;
   localparam logic [5:0] A_RD      = 6'd18;
   localparam logic [5:0] A_PROC    = 6'd19;
   localparam logic [5:0] P_CHK     = 6'd20;
   localparam logic [5:0] P_PROC    = 6'd21;
   localparam logic [5:0] A_INS     = 6'd22;
   localparam logic [5:0] A_INS2    = 6'd23;
   localparam logic [5:0] A_FAIL    = 6'd24;
   localparam logic [5:0] A_FEMIT   = 6'd25;
   localparam logic [5:0] F_RD0     = 6'd26;
   localparam logic [5:0] F_HEAD    = 6'd27;
   localparam logic [5:0] F_RD      = 6'd28;
   localparam logic [5:0] F_PROC    = 6'd29;
   localparam logic [5:0] F_ROV     = 6'd30;
   localparam logic [5:0] F_ROV2    = 6'd31;
   localparam logic [5:0] F_REL     = 6'd32;
   localparam logic [5:0] T_RD      = 6'd33;
   localparam logic [5:0] T_PROC    = 6'd34;

   logic [5:0]           state_ff, state_in;
   pba_pkg::req_type     cmd_ff, cmd_in;
   pba_pkg::link_type    cnt_ff, cnt_in;
   pba_pkg::link_type    scan_ff, scan_in;
   pba_pkg::link_type    last_ff, last_in;
   pba_pkg::link_type    lastscan_ff, lastscan_in;
   pba_pkg::link_type    lsl_ff, lsl_in;
   pba_pkg::link_type    p_ff, p_in;
   pba_pkg::link_type    nx_ff, nx_in;
   pba_pkg::link_type    nw_ff, nw_in;
   pba_pkg::link_type    endscan_ff, endscan_in;
   pba_pkg::addr_type    startseg_ff, startseg_in;
   pba_pkg::addr_type    dest_ff, dest_in;
   logic [1:0]           pass_ff, pass_in;
   pba_pkg::link_type    free_head_ff, free_head_in;
   pba_pkg::link_type    rover_ff, rover_in;
   logic                 sticky_ff, sticky_in;
   logic                 halted_ff, halted_in;

   pba_pkg::addr_type    d_end;
   pba_pkg::addr_type    gap;
   pba_pkg::link_type    ncur;
   pba_pkg::desc_type    upd;
   logic [1:0]           pass_sel;

   function automatic logic is_valid(input pba_pkg::link_type i);
      return i < MAXB;
   endfunction

   // End of the block just read, and the gap in front of it.
   assign d_end = rd_desc.start + rd_desc.length;
   assign gap = rd_desc.start - startseg_ff;
   assign ncur = is_valid(rd_link) ? rd_link : HEAD;
   assign pass_sel = (pass_ff == PASS_HEAD && rover_ff == HEAD) ? PASS_COMPACT : pass_ff;
   assign busy = state_ff != S_IDLE;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      cnt_in = cnt_ff;
      scan_in = scan_ff;
      last_in = last_ff;
      lastscan_in = lastscan_ff;
      lsl_in = lsl_ff;
      p_in = p_ff;
      nx_in = nx_ff;
      nw_in = nw_ff;
      endscan_in = endscan_ff;
      startseg_in = startseg_ff;
      dest_in = dest_ff;
      pass_in = pass_ff;
      free_head_in = free_head_ff;
      rover_in = rover_ff;
      sticky_in = sticky_ff;
      halted_in = halted_ff;
      mreq = '0;
      emit_valid = 1'b0;
      emit = '0;
      upd = rd_desc;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req;
               if (halted_ff) begin
                  state_in = S_HALT;
               end else if (req.command <= pba_pkg::CMD_LOCK && req.handle == '0) begin
                  state_in = S_BADH;
               end else begin
                  case (req.command)
                     pba_pkg::CMD_ALLOC: begin
                        state_in = is_valid(free_head_ff) ? A_TAKE : Q_RD0;
                     end
                     pba_pkg::CMD_FREE: state_in = F_RD0;
                     pba_pkg::CMD_PURGE, pba_pkg::CMD_LOCK: begin
                        scan_in = rover_ff;
                        state_in = T_RD;
                     end
                     pba_pkg::CMD_COMPACT: begin
                        scan_in = HEAD;
                        last_in = pba_pkg::NIL;
                        dest_in = '0;
                        state_in = C_RD;
                     end
                     default: state_in = S_DONE0;
                  endcase
               end
            end
         end
         S_INIT: begin
            mreq.dwr_en = 1'b1;
            mreq.dwr_addr = cnt_ff;
            mreq.lwr_en = 1'b1;
            mreq.lwr_addr = cnt_ff;
            if (cnt_ff == HEAD) begin
               mreq.dwr_data = '{start: cfg.base, length: '0, locked: 1'b1,
                                 purge: 2'd0, owner: '0};
               mreq.lwr_data = HIGH;
            end else if (cnt_ff == HIGH) begin
               mreq.dwr_data = '{start: cfg.end_addr, length: '0, locked: 1'b1,
                                 purge: 2'd0, owner: '0};
               mreq.lwr_data = pba_pkg::NIL;
            end else begin
               mreq.dwr_data = '0;
               mreq.lwr_data = (cnt_ff == LAST_IDX) ? pba_pkg::NIL : cnt_ff + 6'd1;
            end
            if (cnt_ff == LAST_IDX) begin
               free_head_in = FIRST_FREE;
               rover_in = HEAD;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_HALT: begin
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_DONE,
                                   (cmd_ff.command <= pba_pkg::CMD_LOCK) ? cmd_ff.handle : '0,
                                   '0, '0, '0, pba_pkg::STAT_HALTED, sticky_ff, 1'b1);
            state_in = S_IDLE;
         end
         S_BADH: begin
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_DONE, '0, '0, '0, '0,
                                   pba_pkg::STAT_NOTFOUND, sticky_ff, 1'b1);
            state_in = S_IDLE;
         end
         S_DONE0: begin
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_DONE, '0, '0, '0, '0,
                                   pba_pkg::STAT_OK, sticky_ff, 1'b1);
            state_in = S_IDLE;
         end
         S_NF: begin
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_DONE, cmd_ff.handle, '0, '0, '0,
                                   pba_pkg::STAT_NOTFOUND, sticky_ff, 1'b1);
            state_in = S_IDLE;
         end
         S_NODESC: begin
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_DONE, cmd_ff.handle, '0, '0, '0,
                                   pba_pkg::STAT_NODESC, sticky_ff, 1'b1);
            state_in = S_IDLE;
         end
         // Compaction walk.
         C_RD: begin
            if (is_valid(scan_ff)) begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = scan_ff;
               state_in = C_PROC;
            end else begin
               rover_in = HEAD;
               if (cmd_ff.command == pba_pkg::CMD_ALLOC) begin
                  lastscan_in = HEAD;
                  endscan_in = pba_pkg::NIL;
                  mreq.rd_en = 1'b1;
                  mreq.rd_addr = HEAD;
                  state_in = A_LS;
               end else begin
                  state_in = S_DONE0;
               end
            end
         end
         C_PROC: begin
            if (rd_desc.locked) begin
               dest_in = d_end;
               last_in = scan_ff;
               scan_in = rd_link;
               state_in = C_RD;
            end else if (rd_desc.purge != 2'd0) begin
               emit_valid = 1'b1;
               emit = pba_pkg::mk_rsp(pba_pkg::KIND_PURGED, rd_desc.owner, '0, '0, '0,
                                      pba_pkg::STAT_OK, sticky_ff, 1'b0);
               mreq.lwr_en = 1'b1;
               mreq.lwr_addr = scan_ff;
               mreq.lwr_data = free_head_ff;
               free_head_in = scan_ff;
               nx_in = rd_link;
               state_in = C_UNLINK;
            end else begin
               if (rd_desc.start != dest_ff) begin
                  emit_valid = 1'b1;
                  emit = pba_pkg::mk_rsp(pba_pkg::KIND_MOVED, rd_desc.owner, dest_ff,
                                         rd_desc.start, rd_desc.length,
                                         pba_pkg::STAT_OK, sticky_ff, 1'b0);
                  upd.start = dest_ff;
                  mreq.dwr_en = 1'b1;
                  mreq.dwr_addr = scan_ff;
                  mreq.dwr_data = upd;
               end
               dest_in = dest_ff + rd_desc.length;
               last_in = scan_ff;
               scan_in = rd_link;
               state_in = C_RD;
            end
         end
         C_UNLINK: begin
            mreq.lwr_en = 1'b1;
            mreq.lwr_addr = last_ff;
            mreq.lwr_data = nx_ff;
            scan_in = nx_ff;
            state_in = C_RD;
         end
         // No free descriptor: purge the first purgeable block after the head.
         Q_RD0: begin
            mreq.rd_en = 1'b1;
            mreq.rd_addr = HEAD;
            state_in = Q_HEAD;
         end
         Q_HEAD: begin
            scan_in = rd_link;
            last_in = HEAD;
            state_in = Q_RD;
         end
         Q_RD: begin
            if (is_valid(scan_ff)) begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = scan_ff;
               state_in = Q_PROC;
            end else begin
               state_in = S_NODESC;
            end
         end
         Q_PROC: begin
            if (!rd_desc.locked && rd_desc.purge != 2'd0) begin
               if (rover_ff == scan_ff) begin
                  rover_in = HEAD;
               end
               mreq.lwr_en = 1'b1;
               mreq.lwr_addr = last_ff;
               mreq.lwr_data = rd_link;
               emit_valid = 1'b1;
               emit = pba_pkg::mk_rsp(pba_pkg::KIND_PURGED, rd_desc.owner, '0, '0, '0,
                                      pba_pkg::STAT_OK, sticky_ff, 1'b0);
               // The released entry is taken straight back as the new descriptor.
               nw_in = scan_ff;
               pass_in = PASS_ROVER;
               state_in = A_PASS;
            end else begin
               last_in = scan_ff;
               scan_in = rd_link;
               state_in = Q_RD;
            end
         end
         // Take a descriptor from the free list.
         A_TAKE: begin
            mreq.rd_en = 1'b1;
            mreq.rd_addr = free_head_ff;
            state_in = A_TAKE2;
         end
         A_TAKE2: begin
            nw_in = free_head_ff;
            free_head_in = rd_link;
            pass_in = PASS_ROVER;
            state_in = A_PASS;
         end
         // Start of a search pass.
         A_PASS: begin
            pass_in = pass_sel;
            if (pass_sel == PASS_COMPACT) begin
               scan_in = HEAD;
               last_in = pba_pkg::NIL;
               dest_in = '0;
               state_in = C_RD;
            end else begin
               lastscan_in = (pass_sel == PASS_ROVER) ? rover_ff : HEAD;
               endscan_in = (pass_sel == PASS_ROVER) ? pba_pkg::NIL : rover_ff;
               mreq.rd_en = 1'b1;
               mreq.rd_addr = (pass_sel == PASS_ROVER) ? rover_ff : HEAD;
               state_in = A_LS;
            end
         end
         A_LS: begin
            startseg_in = d_end;
            scan_in = rd_link;
            lsl_in = rd_link;
            state_in = A_RD;
         end
         A_RD: begin
            if (scan_ff != endscan_ff && is_valid(scan_ff)) begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = scan_ff;
               state_in = A_PROC;
            end else if (pass_ff == PASS_COMPACT) begin
               state_in = A_FAIL;
            end else begin
               pass_in = pass_ff + 2'd1;
               state_in = A_PASS;
            end
         end
         A_PROC: begin
            if (gap >= cmd_ff.size) begin
               p_in = lsl_ff;
               state_in = P_CHK;
            end else begin
               if (rd_desc.locked || rd_desc.purge == 2'd0) begin
                  lastscan_in = scan_ff;
                  startseg_in = d_end;
                  lsl_in = rd_link;
               end
               scan_in = rd_link;
               state_in = A_RD;
            end
         end
         // Purge the blocks skipped inside the chosen gap.
         P_CHK: begin
            if (p_ff != scan_ff && is_valid(p_ff)) begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = p_ff;
               state_in = P_PROC;
            end else begin
               state_in = A_INS;
            end
         end
         P_PROC: begin
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_PURGED, rd_desc.owner, '0, '0, '0,
                                   pba_pkg::STAT_OK, sticky_ff, 1'b0);
            mreq.lwr_en = 1'b1;
            mreq.lwr_addr = p_ff;
            mreq.lwr_data = free_head_ff;
            free_head_in = p_ff;
            p_in = rd_link;
            state_in = P_CHK;
         end
         // Link the new block in and grant it.
         A_INS: begin
            mreq.lwr_en = 1'b1;
            mreq.lwr_addr = lastscan_ff;
            mreq.lwr_data = nw_ff;
            mreq.dwr_en = 1'b1;
            mreq.dwr_addr = nw_ff;
            mreq.dwr_data = '{start: startseg_ff, length: cmd_ff.size, locked: 1'b0,
                              purge: 2'd0, owner: cmd_ff.handle};
            state_in = A_INS2;
         end
         A_INS2: begin
            mreq.lwr_en = 1'b1;
            mreq.lwr_addr = nw_ff;
            mreq.lwr_data = scan_ff;
            rover_in = nw_ff;
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_GRANT, cmd_ff.handle, startseg_ff, '0, '0,
                                   pba_pkg::STAT_OK, sticky_ff, 1'b1);
            state_in = S_IDLE;
         end
         // Out of memory.
         A_FAIL: begin
            mreq.lwr_en = 1'b1;
            mreq.lwr_addr = nw_ff;
            mreq.lwr_data = free_head_ff;
            free_head_in = nw_ff;
            if (cfg.stop_on_error) begin
               halted_in = 1'b1;
            end else begin
               sticky_in = 1'b1;
            end
            state_in = A_FEMIT;
         end
         A_FEMIT: begin
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_DONE, cmd_ff.handle, '0, '0, '0,
                                   pba_pkg::STAT_NOMEM, sticky_ff, 1'b1);
            state_in = S_IDLE;
         end
         // Free: first match in address order.
         F_RD0: begin
            mreq.rd_en = 1'b1;
            mreq.rd_addr = HEAD;
            state_in = F_HEAD;
         end
         F_HEAD: begin
            scan_in = rd_link;
            last_in = HEAD;
            state_in = F_RD;
         end
         F_RD: begin
            if (is_valid(scan_ff)) begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = scan_ff;
               state_in = F_PROC;
            end else begin
               state_in = S_NF;
            end
         end
         F_PROC: begin
            if (rd_desc.owner == cmd_ff.handle) begin
               nx_in = rd_link;
               state_in = F_ROV;
            end else begin
               last_in = scan_ff;
               scan_in = rd_link;
               state_in = F_RD;
            end
         end
         F_ROV: begin
            mreq.rd_en = 1'b1;
            mreq.rd_addr = rover_ff;
            state_in = F_ROV2;
         end
         F_ROV2: begin
            if (rd_desc.owner == cmd_ff.handle) begin
               rover_in = HEAD;
            end
            mreq.lwr_en = 1'b1;
            mreq.lwr_addr = last_ff;
            mreq.lwr_data = nx_ff;
            state_in = F_REL;
         end
         F_REL: begin
            mreq.lwr_en = 1'b1;
            mreq.lwr_addr = scan_ff;
            mreq.lwr_data = free_head_ff;
            free_head_in = scan_ff;
            emit_valid = 1'b1;
            emit = pba_pkg::mk_rsp(pba_pkg::KIND_DONE, cmd_ff.handle, '0, '0, '0,
                                   pba_pkg::STAT_OK, sticky_ff, 1'b1);
            state_in = S_IDLE;
         end
         // Set purge level or lock: circular search from the rover.
         T_RD: begin
            mreq.rd_en = 1'b1;
            mreq.rd_addr = scan_ff;
            state_in = T_PROC;
         end
         T_PROC: begin
            if (rd_desc.owner == cmd_ff.handle) begin
               rover_in = scan_ff;
               if (cmd_ff.command == pba_pkg::CMD_PURGE) begin
                  upd.purge = cmd_ff.purge_level;
               end else begin
                  upd.locked = cmd_ff.lock_flag;
               end
               mreq.dwr_en = 1'b1;
               mreq.dwr_addr = scan_ff;
               mreq.dwr_data = upd;
               emit_valid = 1'b1;
               emit = pba_pkg::mk_rsp(pba_pkg::KIND_DONE, cmd_ff.handle, '0, '0, '0,
                                      pba_pkg::STAT_OK, sticky_ff, 1'b1);
               state_in = S_IDLE;
            end else if (ncur == rover_ff) begin
               state_in = S_NF;
            end else begin
               scan_in = ncur;
               state_in = T_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // A heap base write rebuilds the table.
      if (reinit) begin
         state_in = S_INIT;
         cnt_in = HEAD;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff <= HEAD;
         free_head_ff <= FIRST_FREE;
         rover_ff <= HEAD;
         sticky_ff <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         free_head_ff <= free_head_in;
         rover_ff <= rover_in;
         sticky_ff <= sticky_in;
         halted_ff <= halted_in;
      end
   end

   // Walk registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      scan_ff <= scan_in;
      last_ff <= last_in;
      lastscan_ff <= lastscan_in;
      lsl_ff <= lsl_in;
      p_ff <= p_in;
      nx_ff <= nx_in;
      nw_ff <= nw_in;
      endscan_ff <= endscan_in;
      startseg_ff <= startseg_in;
      dest_ff <= dest_in;
      pass_ff <= pass_in;
   end

endmodule

`default_nettype wire

[hdl/purgeable_block_allocator.sv]
// Top level of the purgeable block allocator: configuration, sequencer and memory.
`default_nettype none

// Next-fit heap manager over a linked table of MAX_BLOCKS descriptors held
// in a memory with registered read. A command is taken when start is high and
// busy is low; its results follow one per strobe on rsp_valid, the final one
// with last set, and must be taken as they appear. Every descriptor visited
// is read and then acted on once its data is back, and a block purged during
// compaction is then unlinked in a state of its own. Free and lock or purge
// changes walk the list once. An alloc may walk the list once for a spare
// descriptor, once across its first two search passes, once to compact and
// once more for the last pass. After reset and after every heap_base write
// the table of MAX_BLOCKS entries is rebuilt one entry a cycle, with busy
// high.
module purgeable_block_allocator #(
   parameter int MAX_BLOCKS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire pba_pkg::req_type req,
   output logic                  rsp_valid,
   output pba_pkg::rsp_type      rsp,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [23:0]      csr_data
);

   pba_pkg::addr_type    heap_base_ff, heap_base_in;
   pba_pkg::addr_type    heap_size_ff, heap_size_in;
   pba_pkg::addr_type    init_end_ff, init_end_in;
   logic                 stop_ff, stop_in;
   logic                 rsp_valid_ff;
   pba_pkg::rsp_type     rsp_ff;
   logic                 csr_wr;
   logic                 reinit;
   pba_pkg::cfg_type     cfg;
   pba_pkg::mem_req_type mreq;
   pba_pkg::desc_type    rd_desc;
   pba_pkg::link_type    rd_link;
   logic                 emit_valid;
   pba_pkg::rsp_type     emit;

   assign csr_ready = 1'b1;
   assign csr_wr = csr_valid && csr_ready;
   assign reinit = csr_wr && csr_index == pba_pkg::CSR_HEAP_BASE;

   // Register writes; the high sentinel address is fixed when the table is rebuilt.
   always_comb begin
      heap_base_in = heap_base_ff;
      heap_size_in = heap_size_ff;
      init_end_in = init_end_ff;
      stop_in = stop_ff;
      if (csr_wr) begin
         case (csr_index)
            pba_pkg::CSR_HEAP_BASE: begin
               heap_base_in = csr_data;
               init_end_in = csr_data + heap_size_ff;
            end
            pba_pkg::CSR_HEAP_SIZE: heap_size_in = csr_data;
            pba_pkg::CSR_STOP: stop_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         heap_size_ff <= 24'd524288;
         init_end_ff <= 24'd524288;
         stop_ff <= 1'b1;
      end else begin
         heap_base_ff <= heap_base_in;
         heap_size_ff <= heap_size_in;
         init_end_ff <= init_end_in;
         stop_ff <= stop_in;
      end
   end

   assign cfg = '{base: heap_base_ff, end_addr: init_end_ff, stop_on_error: stop_ff};

   pba_seq #(.MAX_BLOCKS(MAX_BLOCKS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req),
      .busy       (busy),
      .cfg        (cfg),
      .reinit     (reinit),
      .mreq       (mreq),
      .rd_desc    (rd_desc),
      .rd_link    (rd_link),
      .emit_valid (emit_valid),
      .emit       (emit)
   );

   pba_desc_mem #(.MAX_BLOCKS(MAX_BLOCKS)) u_mem (
      .clock   (clock),
      .mreq    (mreq),
      .rd_desc (rd_desc),
      .rd_link (rd_link)
   );

   // Result register: each item shows for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_valid;
      end
      rsp_ff <= emit;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

`default_nettype wire

[hdl/pba_checker.sv]
// Port-level checks of the purgeable block allocator and their binding.
`default_nettype none

module pba_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire pba_pkg::rsp_type rsp
);

   // An accepted command keeps the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting an item");

   // The final item of a command is never followed directly by another item.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last |=> !rsp_valid)
      else $error("item directly after final item");

   // Error completions end the command.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != pba_pkg::STAT_OK |-> rsp.last)
      else $error("error status on an item that is not final");

   // Purge and move reports carry good status and are never final.
   a_report_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.kind == pba_pkg::KIND_PURGED || rsp.kind == pba_pkg::KIND_MOVED)
      |-> rsp.status == pba_pkg::STAT_OK && !rsp.last)
      else $error("bad purge or move report");

endmodule

bind purgeable_block_allocator pba_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the purgeable block allocator, checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int NBLK = 32;
   localparam int NOLINK = 63;
   localparam int DRAIN_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pba_pkg::req_type req = '0;
   logic rsp_valid;
   pba_pkg::rsp_type rsp;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   purgeable_block_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the descriptor table and configuration.
   pba_pkg::addr_type blk_start [NBLK];
   pba_pkg::addr_type blk_len [NBLK];
   logic              blk_lock [NBLK];
   logic [1:0]        blk_purge [NBLK];
   logic [7:0]        blk_owner [NBLK];
   int                blk_link [NBLK];
   int                head_idx, free_idx, rover_idx;
   logic              sticky_err, is_halted;
   pba_pkg::addr_type base_reg, size_reg;
   logic              stop_reg;

   pba_pkg::rsp_type expected_rsps[$];
   int fail_count = 0;
   int items_sent = 0;
   int rsps_seen = 0;

   // Queues one expected result, carrying the current sticky error.
   function automatic void push_rsp(logic [1:0] k, logic [7:0] o, pba_pkg::addr_type a,
                                    pba_pkg::addr_type s, pba_pkg::addr_type l,
                                    logic [2:0] st, logic lst);
      pba_pkg::rsp_type r;
      r.kind = k; r.owner = o; r.address = a; r.source_address = s;
      r.move_length = l; r.status = st; r.error_flag = sticky_err; r.last = lst;
      expected_rsps.push_back(r);
   endfunction

   function automatic bit ok_idx(int i);
      return i >= 0 && i < NBLK;
   endfunction

   function automatic pba_pkg::addr_type blk_end(int i);
      if (!ok_idx(i)) return '0;
      return blk_start[i] + blk_len[i];
   endfunction

   function automatic void give_back(int i);
      if (!ok_idx(i)) return;
      blk_link[i] = free_idx;
      free_idx = i;
   endfunction

   function automatic void rebuild_table();
      for (int i = 0; i < NBLK; i++) begin
         blk_link[i] = (i + 1 < NBLK) ? i + 1 : NOLINK;
      end
      head_idx = 0;
      blk_start[0] = base_reg; blk_len[0] = '0; blk_lock[0] = 1'b1;
      blk_purge[0] = '0; blk_owner[0] = '0; blk_link[0] = 1;
      blk_start[1] = base_reg + size_reg; blk_len[1] = '0; blk_lock[1] = 1'b1;
      blk_purge[1] = '0; blk_owner[1] = '0; blk_link[1] = NOLINK;
      free_idx = 2;
      rover_idx = 0;
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < NBLK; i++) begin
         blk_start[i] = '0; blk_len[i] = '0; blk_lock[i] = 1'b0;
         blk_purge[i] = '0; blk_owner[i] = '0;
      end
      base_reg = '0; size_reg = 24'd524288; stop_reg = 1'b1;
      sticky_err = 1'b0; is_halted = 1'b0;
      rebuild_table();
   endfunction

   // Purges unlocked purgeable blocks and slides the other unlocked blocks down.
   function automatic void do_compact();
      int scan, prev, steps, nx;
      pba_pkg::addr_type dest;
      scan = head_idx; prev = NOLINK; steps = 0; dest = '0;
      while (ok_idx(scan) && steps <= NBLK) begin
         steps++;
         if (blk_lock[scan]) begin
            dest = blk_end(scan);
         end else if (blk_purge[scan] != 0) begin
            nx = blk_link[scan];
            push_rsp(pba_pkg::KIND_PURGED, blk_owner[scan], '0, '0, '0,
                     pba_pkg::STAT_OK, 1'b0);
            give_back(scan);
            if (ok_idx(prev)) blk_link[prev] = nx;
            else head_idx = nx;
            scan = nx;
            continue;
         end else begin
            if (blk_start[scan] != dest) begin
               push_rsp(pba_pkg::KIND_MOVED, blk_owner[scan], dest, blk_start[scan],
                        blk_len[scan], pba_pkg::STAT_OK, 1'b0);
               blk_start[scan] = dest;
            end
            dest = blk_end(scan);
         end
         prev = scan;
         scan = blk_link[scan];
      end
      rover_idx = head_idx;
   endfunction

   // Frees the first purgeable block when descriptors run out.
   function automatic bit purge_one();
      int prev, scan, steps;
      prev = head_idx;
      scan = ok_idx(head_idx) ? blk_link[head_idx] : NOLINK;
      steps = 0;
      while (ok_idx(scan) && steps <= NBLK) begin
         steps++;
         if (!blk_lock[scan] && blk_purge[scan] != 0) begin
            if (rover_idx == scan) rover_idx = head_idx;
            blk_link[prev] = blk_link[scan];
            push_rsp(pba_pkg::KIND_PURGED, blk_owner[scan], '0, '0, '0,
                     pba_pkg::STAT_OK, 1'b0);
            give_back(scan);
            return 1'b1;
         end
         prev = scan;
         scan = blk_link[scan];
      end
      return 1'b0;
   endfunction

   function automatic void do_alloc(logic [7:0] hnd, pba_pkg::addr_type sz);
      int nw, pass, lastscan, scan, endscan, p, pn, steps;
      pba_pkg::addr_type seg;
      if (!ok_idx(free_idx) && !purge_one()) begin
         push_rsp(pba_pkg::KIND_DONE, hnd, '0, '0, '0, pba_pkg::STAT_NODESC, 1'b1);
         return;
      end
      nw = free_idx;
      free_idx = blk_link[nw];
      for (pass = 0; pass < 3; pass++) begin
         if (pass == 1 && rover_idx == head_idx) pass = 2;
         if (pass == 0) begin
            lastscan = rover_idx; endscan = NOLINK;
         end else if (pass == 1) begin
            lastscan = head_idx; endscan = rover_idx;
         end else begin
            do_compact();
            lastscan = head_idx; endscan = NOLINK;
         end
         scan = ok_idx(lastscan) ? blk_link[lastscan] : NOLINK;
         seg = blk_end(lastscan);
         steps = 0;
         while (scan != endscan && ok_idx(scan) && steps <= NBLK) begin
            steps++;
            if (pba_pkg::addr_type'(blk_start[scan] - seg) >= sz) begin
               p = blk_link[lastscan];
               while (p != scan && ok_idx(p)) begin
                  pn = blk_link[p];
                  push_rsp(pba_pkg::KIND_PURGED, blk_owner[p], '0, '0, '0,
                           pba_pkg::STAT_OK, 1'b0);
                  give_back(p);
                  p = pn;
               end
               blk_link[lastscan] = nw;
               blk_start[nw] = seg; blk_len[nw] = sz; blk_lock[nw] = 1'b0;
               blk_purge[nw] = '0; blk_owner[nw] = hnd; blk_link[nw] = scan;
               rover_idx = nw;
               push_rsp(pba_pkg::KIND_GRANT, hnd, seg, '0, '0, pba_pkg::STAT_OK, 1'b1);
               return;
            end
            if (blk_lock[scan] || blk_purge[scan] == 0) begin
               lastscan = scan;
               seg = blk_end(scan);
            end
            scan = blk_link[scan];
         end
      end
      give_back(nw);
      if (stop_reg) is_halted = 1'b1;
      else sticky_err = 1'b1;
      push_rsp(pba_pkg::KIND_DONE, hnd, '0, '0, '0, pba_pkg::STAT_NOMEM, 1'b1);
   endfunction

   function automatic void do_free(logic [7:0] hnd);
      int prev, scan, steps;
      prev = head_idx;
      scan = ok_idx(head_idx) ? blk_link[head_idx] : NOLINK;
      steps = 0;
      while (ok_idx(scan) && blk_owner[scan] != hnd && steps <= NBLK) begin
         steps++;
         prev = scan;
         scan = blk_link[scan];
      end
      if (!ok_idx(scan) || blk_owner[scan] != hnd) begin
         push_rsp(pba_pkg::KIND_DONE, hnd, '0, '0, '0, pba_pkg::STAT_NOTFOUND, 1'b1);
         return;
      end
      if (ok_idx(rover_idx) && blk_owner[rover_idx] == hnd) rover_idx = head_idx;
      blk_link[prev] = blk_link[scan];
      give_back(scan);
      push_rsp(pba_pkg::KIND_DONE, hnd, '0, '0, '0, pba_pkg::STAT_OK, 1'b1);
   endfunction

   // Circular search for a handle, starting at the rover.
   function automatic int find_owner(logic [7:0] hnd);
      int cur;
      cur = rover_idx;
      for (int n = 0; n <= NBLK && ok_idx(cur); n++) begin
         if (blk_owner[cur] == hnd) return cur;
         cur = blk_link[cur];
         if (!ok_idx(cur)) cur = head_idx;
         if (cur == rover_idx) break;
      end
      return NOLINK;
   endfunction

   // Works out every result that one accepted command causes.
   function automatic void predict_cmd(pba_pkg::req_type r);
      int b;
      if (is_halted) begin
         push_rsp(pba_pkg::KIND_DONE, (r.command <= pba_pkg::CMD_LOCK) ? r.handle : 8'd0,
                  '0, '0, '0, pba_pkg::STAT_HALTED, 1'b1);
         return;
      end
      if (r.command <= pba_pkg::CMD_LOCK && r.handle == 0) begin
         push_rsp(pba_pkg::KIND_DONE, '0, '0, '0, '0, pba_pkg::STAT_NOTFOUND, 1'b1);
         return;
      end
      case (r.command)
         pba_pkg::CMD_ALLOC: do_alloc(r.handle, r.size);
         pba_pkg::CMD_FREE: do_free(r.handle);
         pba_pkg::CMD_PURGE, pba_pkg::CMD_LOCK: begin
            b = find_owner(r.handle);
            if (!ok_idx(b)) begin
               push_rsp(pba_pkg::KIND_DONE, r.handle, '0, '0, '0,
                        pba_pkg::STAT_NOTFOUND, 1'b1);
            end else begin
               rover_idx = b;
               if (r.command == pba_pkg::CMD_PURGE) blk_purge[b] = r.purge_level;
               else blk_lock[b] = r.lock_flag;
               push_rsp(pba_pkg::KIND_DONE, r.handle, '0, '0, '0, pba_pkg::STAT_OK, 1'b1);
            end
         end
         pba_pkg::CMD_COMPACT: begin
            do_compact();
            push_rsp(pba_pkg::KIND_DONE, '0, '0, '0, '0, pba_pkg::STAT_OK, 1'b1);
         end
         default: push_rsp(pba_pkg::KIND_DONE, '0, '0, '0, '0, pba_pkg::STAT_OK, 1'b1);
      endcase
   endfunction

   // Compares each result with the oldest expectation.
   always @(posedge clock) begin
      pba_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         rsps_seen++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected result: kind %0d owner %0d", rsp.kind, rsp.owner);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp.kind !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp.kind); fail_count++;
            end
            if (rsp.owner !== e.owner) begin
               $error("owner: expected %0d, got %0d", e.owner, rsp.owner); fail_count++;
            end
            if (rsp.address !== e.address) begin
               $error("address: expected %h, got %h", e.address, rsp.address);
               fail_count++;
            end
            if (rsp.source_address !== e.source_address) begin
               $error("source_address: expected %h, got %h", e.source_address,
                      rsp.source_address);
               fail_count++;
            end
            if (rsp.move_length !== e.move_length) begin
               $error("move_length: expected %h, got %h", e.move_length,
                      rsp.move_length);
               fail_count++;
            end
            if (rsp.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp.status);
               fail_count++;
            end
            if (rsp.error_flag !== e.error_flag) begin
               $error("error_flag: expected %0d, got %0d", e.error_flag,
                      rsp.error_flag);
               fail_count++;
            end
            if (rsp.last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp.last); fail_count++;
            end
         end
      end
   end

   // Idle cycles between items: mostly none or short, now and then long.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Sends one command item and records what it should produce.
   task automatic send_cmd(logic [2:0] cmd, logic [7:0] hnd, pba_pkg::addr_type sz,
                           logic [1:0] pl, logic lk);
      pba_pkg::req_type r;
      r.command = cmd; r.handle = hnd; r.size = sz; r.purge_level = pl;
      r.lock_flag = lk;
      req = r;
      start = 1'b1;
      do @(posedge clock); while (busy);
      predict_cmd(r);
      items_sent++;
      @(negedge clock);
      idle_gap();
   endtask

   // Waits until every expected result has come and the block has settled.
   task automatic drain();
      start = 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] val);
      drain();
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pba_pkg::CSR_HEAP_BASE: begin
            base_reg = val;
            rebuild_table();
         end
         pba_pkg::CSR_HEAP_SIZE: size_reg = val;
         pba_pkg::CSR_STOP: stop_reg = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_handle();
      case ($urandom_range(0, 19))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(1, 255));
         default: return 8'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic pba_pkg::addr_type pick_size(int typical);
      case ($urandom_range(0, 24))
         0: return pba_pkg::addr_type'($urandom);
         1: return 24'hFFFFFF;
         2: return '0;
         default: return pba_pkg::addr_type'($urandom_range(1, typical));
      endcase
   endfunction

   // Directed checks of each command and the corner cases at reset settings.
   task automatic test_commands();
      send_cmd(pba_pkg::CMD_ALLOC, 8'd1, 24'd256, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd2, 24'd0, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd255, 24'd100, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd3, 24'd64, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd3, 24'd32, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_PURGE, 8'd2, '0, 2'd3, 1'b0);
      send_cmd(pba_pkg::CMD_LOCK, 8'd255, '0, 2'd0, 1'b1);
      send_cmd(pba_pkg::CMD_PURGE, 8'd3, '0, 2'd1, 1'b0);
      send_cmd(pba_pkg::CMD_FREE, 8'd1, '0, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_FREE, 8'd77, '0, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_LOCK, 8'd99, '0, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd0, 24'd8, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_FREE, 8'd0, '0, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_PURGE, 8'd0, '0, 2'd2, 1'b0);
      send_cmd(pba_pkg::CMD_LOCK, 8'd0, '0, 2'd0, 1'b1);
      send_cmd(pba_pkg::CMD_COMPACT, 8'd0, '0, 2'd0, 1'b0);
      send_cmd(3'd5, 8'd4, 24'd1, 2'd1, 1'b1);
      send_cmd(3'd6, 8'd0, '0, 2'd0, 1'b0);
      send_cmd(3'd7, 8'd255, 24'hFFFFFF, 2'd3, 1'b1);
      send_cmd(pba_pkg::CMD_LOCK, 8'd255, '0, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_COMPACT, 8'd9, '0, 2'd0, 1'b0);
   endtask

   // Runs the table out of descriptors, with and without purgeable blocks.
   task automatic test_exhaustion();
      write_csr(pba_pkg::CSR_STOP, 24'd0);
      write_csr(pba_pkg::CSR_HEAP_SIZE, 24'd4096);
      write_csr(pba_pkg::CSR_HEAP_BASE, 24'h000100);
      for (int i = 1; i <= NBLK; i++) begin
         send_cmd(pba_pkg::CMD_ALLOC, 8'(i), 24'd16, 2'd0, 1'b0);
      end
      send_cmd(pba_pkg::CMD_PURGE, 8'd7, '0, 2'd2, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd40, 24'd8, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd41, 24'd8, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd42, 24'hFFFFFF, 2'd0, 1'b0);
   endtask

   // Random commands, weighted toward allocation so that the table fills.
   task automatic test_random(int count, int typical);
      int c;
      for (int i = 0; i < count; i++) begin
         c = $urandom_range(0, 99);
         if (c < 40) send_cmd(pba_pkg::CMD_ALLOC, pick_handle(), pick_size(typical),
                              2'($urandom), 1'($urandom));
         else if (c < 60) send_cmd(pba_pkg::CMD_FREE, pick_handle(),
                                   pba_pkg::addr_type'($urandom),
                                   2'($urandom), 1'($urandom));
         else if (c < 78) send_cmd(pba_pkg::CMD_PURGE, pick_handle(),
                                   pba_pkg::addr_type'($urandom),
                                   2'($urandom), 1'($urandom));
         else if (c < 92) send_cmd(pba_pkg::CMD_LOCK, pick_handle(),
                                   pba_pkg::addr_type'($urandom),
                                   2'($urandom), 1'($urandom));
         else if (c < 97) send_cmd(pba_pkg::CMD_COMPACT, pick_handle(),
                                   pba_pkg::addr_type'($urandom),
                                   2'($urandom), 1'($urandom));
         else send_cmd(3'($urandom_range(5, 7)), pick_handle(),
                       pba_pkg::addr_type'($urandom), 2'($urandom), 1'($urandom));
         if (i == count / 2) drain();
      end
   endtask

   // Heaps at the edges of the address space, including a wrapping one.
   task automatic test_heap_shapes();
      write_csr(pba_pkg::CSR_HEAP_SIZE, 24'h000300);
      write_csr(pba_pkg::CSR_HEAP_BASE, 24'hFFFF00);
      test_random(60, 120);
      write_csr(pba_pkg::CSR_HEAP_SIZE, 24'd0);
      write_csr(pba_pkg::CSR_HEAP_BASE, 24'd0);
      test_random(15, 40);
      write_csr(pba_pkg::CSR_HEAP_SIZE, 24'hFFFFFF);
      write_csr(pba_pkg::CSR_HEAP_BASE, 24'h800000);
      test_random(50, 4000000);
      write_csr(pba_pkg::CSR_HEAP_SIZE, 24'd2048);
      write_csr(pba_pkg::CSR_HEAP_BASE, pba_pkg::addr_type'($urandom));
      test_random(80, 200);
   endtask

   // Out of memory with halting enabled: everything after answers halted.
   task automatic test_halt();
      write_csr(pba_pkg::CSR_STOP, 24'd1);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd5, 24'd16, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_ALLOC, 8'd6, 24'hFFFFFF, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_FREE, 8'd5, '0, 2'd0, 1'b0);
      send_cmd(pba_pkg::CMD_COMPACT, 8'd5, '0, 2'd0, 1'b0);
      send_cmd(3'd6, 8'd5, '0, 2'd0, 1'b0);
   endtask

   initial begin
      shadow_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_commands();
      test_exhaustion();
      test_heap_shapes();
      test_halt();
      drain();
      $display("Sent %0d commands over six heap layouts; checked %0d results.",
               items_sent, rsps_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/pba_pkg.sv
hdl/pba_desc_mem.sv
hdl/pba_seq.sv
hdl/purgeable_block_allocator.sv
hdl/pba_checker.sv
tb/sv/tb_top.sv
